>>> src/fmovq_pkg.sv
// Shared constants and types for the FMOV immediate quantizer.
package fmovq_pkg;

	localparam int CODE_W  = 7;
	localparam int REG_W   = 5;
	localparam int VALUE_W = 29;
	localparam int TARGET_W = 32;
	localparam int GROUPS  = 8;

	// single-precision FMOV (immediate) opcode with the imm8 field cleared
	localparam logic [VALUE_W-1:0] FMOV_BASE = 29'h1E20_1000;
	localparam int IMM_SHIFT = 13;

	// tag that rides along the cell row
	typedef struct packed {
		logic [REG_W-1:0]  dest;
		logic [CODE_W-1:0] code;
	} fmovq_tag_t;

endpackage

>>> src/fmovq_cell.sv
// One cell of the search row: nearest candidate within one exponent group, kept if it beats the incoming best.
module fmovq_cell #(
	parameter int FRAC_BITS = 24,
	parameter int GROUP     = 0,
	parameter int W         = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       up_valid,
	output logic                       up_ready,
	input  logic [fmovq_pkg::TARGET_W-1:0] up_target,
	input  fmovq_pkg::fmovq_tag_t      up_tag,
	input  logic [W-1:0]               up_diff,
	output logic                       dn_valid,
	input  logic                       dn_ready,
	output logic [fmovq_pkg::TARGET_W-1:0] dn_target,
	output fmovq_pkg::fmovq_tag_t      dn_tag,
	output logic [W-1:0]               dn_diff
);
	import fmovq_pkg::*;

	// code bits [6:4] = GROUP; exponent field is {!b, cd}
	localparam int EXP = (((GROUP >> 2) & 1) ^ 1) * 4 + (GROUP & 3);
	localparam int S   = FRAC_BITS + EXP - 7;
	localparam logic [2:0]   GRP  = 3'(GROUP);
	localparam logic [W-1:0] STEP = {{(W-1){1'b0}}, 1'b1} << S;
	localparam logic [W-1:0] V16  = STEP << 4;
	localparam logic [W-1:0] V31  = (STEP << 5) - STEP;
	localparam logic [W-1:0] HALF = STEP >> 1;
	localparam logic [W-1:0] MASK = STEP - {{(W-1){1'b0}}, 1'b1};

	logic [W-1:0] tgt;
	logic [W-1:0] q;
	logic [W-1:0] rem;
	logic [W-1:0] diff;
	logic [3:0]   mant;
	fmovq_tag_t   tag_next;
	logic         valid_q;
	logic [TARGET_W-1:0] target_q;
	fmovq_tag_t   tag_q;
	logic [W-1:0] diff_q;

	assign tgt = W'(up_target);
	assign q   = tgt >> S;
	assign rem = tgt & MASK;

	always_comb begin
		priority if (tgt < V16) begin
			mant = 4'd0;
			diff = V16 - tgt;
		end else if (tgt >= V31) begin
			mant = 4'd15;
			diff = tgt - V31;
		end else if (rem > HALF) begin
			// round up; an exact halfway point stays on the smaller code
			mant = q[3:0] + 4'd1;
			diff = STEP - rem;
		end else begin
			mant = q[3:0];
			diff = rem;
		end
	end

	always_comb begin
		tag_next = up_tag;
		if (diff < up_diff) begin
			tag_next.code = {GRP, mant};
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			target_q <= up_target;
			tag_q    <= tag_next;
			diff_q   <= (diff < up_diff) ? diff : up_diff;
		end
	end

	assign dn_valid  = valid_q;
	assign dn_target = target_q;
	assign dn_tag    = tag_q;
	assign dn_diff   = diff_q;

endmodule

>>> src/fmovq_out.sv
// Output stage: expands the chosen code into its value and instruction word.
module fmovq_out #(
	parameter int FRAC_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  fmovq_pkg::fmovq_tag_t up_tag,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [fmovq_pkg::CODE_W-1:0]  out_code,
	output logic [fmovq_pkg::VALUE_W-1:0] out_value,
	output logic [fmovq_pkg::VALUE_W-1:0] out_instr
);
	import fmovq_pkg::*;

	localparam int VW = (FRAC_BITS + 5 > VALUE_W) ? FRAC_BITS + 5 : VALUE_W;

	logic [2:0]         exp_f;
	logic [VW-1:0]      val;
	logic [VALUE_W-1:0] instr;
	logic               valid_q;
	logic [CODE_W-1:0]  code_q;
	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] instr_q;

	assign exp_f = {~up_tag.code[6], up_tag.code[5:4]};
	assign val   = (VW'({1'b1, up_tag.code[3:0]}) << (FRAC_BITS - 7)) << exp_f;
	assign instr = FMOV_BASE | (VALUE_W'(up_tag.code) << IMM_SHIFT) | VALUE_W'(up_tag.dest);

	assign up_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			code_q  <= up_tag.code;
			value_q <= val[VALUE_W-1:0];
			instr_q <= instr;
		end
	end

	assign out_valid = valid_q;
	assign out_code  = code_q;
	assign out_value = value_q;
	assign out_instr = instr_q;

endmodule

>>> src/fmov_immediate_quantizer.sv
// Top level of the FMOV immediate quantizer: a row of search cells and an output stage.
//
// Each word on the input stream carries an unsigned fixed-point target (TARGET_FRACTION_BITS
// fraction bits) and a destination register number. The block picks the positive 8-bit
// floating-point immediate nearest the target (0.125 to 31, ties to the smaller code) and
// returns the code, its exact fixed-point value and the FMOV single-precision instruction.
// A row of eight cells, one per exponent group in code order, each keeps the best code so
// far and hands it to the next cell when that cell can take it; an output register follows.
// Each word passes nine register stages, the first loaded at the accepting edge. The block
// takes one word per cycle while the receiver keeps up; every cell and the output stage
// are registered.
// Each stage advances when its own register is empty or the next stage takes its word, so
// a stalled receiver fills the row from the end while the input keeps taking words until
// the row is full; no word is lost or repeated.
// Reset clears all valid flags; the block is ready in the first cycle after reset.
module fmov_immediate_quantizer #(
	parameter int TARGET_FRACTION_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [31:0] target_value, [36:32] dest_register, zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // [6:0] imm_code, [35:7] encoded_value,
	                                   // [64:36] instruction_word, zero pad
);
	import fmovq_pkg::*;

	localparam int W = (TARGET_FRACTION_BITS + 5 > TARGET_W) ?
		TARGET_FRACTION_BITS + 5 : TARGET_W;

	logic                valid [0:GROUPS];
	logic                ready [0:GROUPS];
	logic [TARGET_W-1:0] target [0:GROUPS];
	fmovq_tag_t          tag [0:GROUPS];
	logic [W-1:0]        diff [0:GROUPS];

	logic [CODE_W-1:0]  imm_code;
	logic [VALUE_W-1:0] encoded_value;
	logic [VALUE_W-1:0] instruction_word;

	assign valid[0]    = s_axis_tvalid;
	assign s_axis_tready = ready[0];
	assign target[0]   = s_axis_tdata[TARGET_W-1:0];
	assign tag[0].dest = s_axis_tdata[TARGET_W +: REG_W];
	assign tag[0].code = '0;
	// start above any reachable distance so the first cell always wins
	assign diff[0]     = '1;

	for (genvar g = 0; g < GROUPS; g++) begin : g_cell
		fmovq_cell #(
			.FRAC_BITS (TARGET_FRACTION_BITS),
			.GROUP     (g),
			.W         (W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.up_valid  (valid[g]),
			.up_ready  (ready[g]),
			.up_target (target[g]),
			.up_tag    (tag[g]),
			.up_diff   (diff[g]),
			.dn_valid  (valid[g+1]),
			.dn_ready  (ready[g+1]),
			.dn_target (target[g+1]),
			.dn_tag    (tag[g+1]),
			.dn_diff   (diff[g+1])
		);
	end

	fmovq_out #(
		.FRAC_BITS (TARGET_FRACTION_BITS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (valid[GROUPS] && (target[GROUPS] == target[GROUPS] ||
			diff[GROUPS] == diff[GROUPS])),
		.up_ready  (ready[GROUPS]),
		.up_tag    (tag[GROUPS]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_code  (imm_code),
		.out_value (encoded_value),
		.out_instr (instruction_word)
	);

	assign m_axis_tdata = {7'd0, instruction_word, encoded_value, imm_code};

endmodule
